// ===== rtl/cc20_pkg.sv =====
`timescale 1ns / 1ps

package cc20_pkg;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646E;
    localparam logic [31:0] SIGMA2 = 32'h7962_2D32;
    localparam logic [31:0] SIGMA3 = 32'h6B20_6574;

    localparam int NUM_ROUNDS    = 20;
    localparam int CC_FIFO_DEPTH = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR = 3'd6;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        first;
    } in_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic [2:0]  result_bytes;
    } out_t;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_low;
        logic [31:0]      nonce_high;
        logic [31:0]      init_ctr;
    } cfg_t;

    // one classified word on its way from front to core
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        new_block;
        logic [31:0] ctr;
        logic [3:0]  pos;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } core_stat_t;

    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_t;

    function automatic qr_t quarter(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input logic [31:0] d);
        qr_t q;
        logic [31:0] ta, tb, tc, td;
        ta = a + b;
        td = d ^ ta;
        td = {td[15:0], td[31:16]};
        tc = c + td;
        tb = b ^ tc;
        tb = {tb[19:0], tb[31:20]};
        ta = ta + tb;
        td = td ^ ta;
        td = {td[23:0], td[31:24]};
        tc = tc + td;
        tb = tb ^ tc;
        tb = {tb[24:0], tb[31:25]};
        q.a = ta;
        q.b = tb;
        q.c = tc;
        q.d = td;
        return q;
    endfunction

    // word index of row 'row' in lane 'lane'; diagonal rounds skew the lane by the row
    function automatic logic [3:0] qr_idx(input logic [1:0] lane, input logic [1:0] row,
                                          input logic diag);
        logic [1:0] col;
        col = lane + (diag ? row : 2'd0);
        return {row, col};
    endfunction

    function automatic block_t init_block(input cfg_t cfg, input logic [31:0] ctr);
        block_t b;
        b[0]  = SIGMA0;
        b[1]  = SIGMA1;
        b[2]  = SIGMA2;
        b[3]  = SIGMA3;
        b[4]  = cfg.key[0][31:0];
        b[5]  = cfg.key[0][63:32];
        b[6]  = cfg.key[1][31:0];
        b[7]  = cfg.key[1][63:32];
        b[8]  = cfg.key[2][31:0];
        b[9]  = cfg.key[2][63:32];
        b[10] = cfg.key[3][31:0];
        b[11] = cfg.key[3][63:32];
        b[12] = ctr;
        b[13] = cfg.nonce_low[31:0];
        b[14] = cfg.nonce_low[63:32];
        b[15] = cfg.nonce_high;
        return b;
    endfunction

    function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic out_t make_out(input cmd_t cmd, input logic [31:0] ks);
        out_t o;
        o.result_word  = (cmd.data_word ^ ks) & byte_mask(cmd.byte_count);
        o.result_bytes = cmd.byte_count;
        return o;
    endfunction

endpackage

// ===== rtl/cc20_front.sv =====
`timescale 1ns / 1ps

module cc20_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  cc20_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  cc20_pkg::in_t   s_data,
    output logic            push_valid,
    input  logic            push_ready,
    output cc20_pkg::cmd_t  push_cmd
);

    logic [31:0] ctr_reg, ctr_next;
    logic [3:0]  pos_reg, pos_next;
    logic        kv_reg, kv_next;

    logic [31:0] f_ctr;
    logic [3:0]  f_pos;
    logic [3:0]  use_pos;
    logic        f_kv;
    logic        accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        f_ctr   = s_data.first ? cfg.init_ctr : ctr_reg;
        f_kv    = s_data.first ? 1'b0 : kv_reg;
        f_pos   = s_data.first ? 4'd0 : pos_reg;
        use_pos = f_kv ? f_pos : 4'd0;

        push_cmd.data_word  = s_data.data_word;
        push_cmd.byte_count = s_data.byte_count;
        push_cmd.new_block  = !f_kv;
        push_cmd.ctr        = f_ctr;
        push_cmd.pos        = use_pos;

        ctr_next = ctr_reg;
        pos_next = pos_reg;
        kv_next  = kv_reg;
        if (accept) begin
            ctr_next = f_kv ? f_ctr : f_ctr + 32'd1;
            pos_next = use_pos + 4'd1;
            kv_next  = (use_pos != 4'd15);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
            pos_reg <= '0;
            kv_reg  <= 1'b0;
        end else begin
            ctr_reg <= ctr_next;
            pos_reg <= pos_next;
            kv_reg  <= kv_next;
        end
    end

endmodule

// ===== rtl/cc20_fifo.sv =====
`timescale 1ns / 1ps

module cc20_fifo #(
    parameter int DEPTH = cc20_pkg::CC_FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  cc20_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cc20_pkg::cmd_t  pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cc20_pkg::cmd_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_ready && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/cc20_core.sv =====
`timescale 1ns / 1ps

module cc20_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cc20_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  cc20_pkg::cmd_t       q_cmd,
    output cc20_pkg::core_stat_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cc20_pkg::out_t       m_data
);

    localparam int RND_W = $clog2(cc20_pkg::NUM_ROUNDS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [RND_W-1:0] round_reg, round_next;
    logic             out_valid_reg, out_valid_next;
    cc20_pkg::block_t w_reg, w_next;
    cc20_pkg::cmd_t   cur_reg, cur_next;
    cc20_pkg::out_t   out_reg, out_next;

    cc20_pkg::block_t w_rnd, w_ff, init_cur;
    cc20_pkg::qr_t    qr_res;
    logic             diag;
    logic             out_free;
    logic             pop;

    assign diag     = round_reg[0];
    assign out_free = !out_valid_reg || m_ready;
    assign init_cur = cc20_pkg::init_block(cfg, cur_reg.ctr);

    // one round a cycle: four quarter-rounds side by side
    always_comb begin
        w_rnd  = w_reg;
        qr_res = '0;
        for (int i = 0; i < 4; i++) begin
            qr_res = cc20_pkg::quarter(w_reg[cc20_pkg::qr_idx(2'(i), 2'd0, diag)],
                                       w_reg[cc20_pkg::qr_idx(2'(i), 2'd1, diag)],
                                       w_reg[cc20_pkg::qr_idx(2'(i), 2'd2, diag)],
                                       w_reg[cc20_pkg::qr_idx(2'(i), 2'd3, diag)]);
            w_rnd[cc20_pkg::qr_idx(2'(i), 2'd0, diag)] = qr_res.a;
            w_rnd[cc20_pkg::qr_idx(2'(i), 2'd1, diag)] = qr_res.b;
            w_rnd[cc20_pkg::qr_idx(2'(i), 2'd2, diag)] = qr_res.c;
            w_rnd[cc20_pkg::qr_idx(2'(i), 2'd3, diag)] = qr_res.d;
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_ff[i] = w_reg[i] + init_cur[i];
        end
    end

    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        w_next         = w_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.new_block) begin
                        pop        = 1'b1;
                        cur_next   = q_cmd;
                        w_next     = cc20_pkg::init_block(cfg, q_cmd.ctr);
                        round_next = '0;
                        state_next = ST_ROUND;
                    end else if (out_free) begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_next       = cc20_pkg::make_out(q_cmd, w_reg[q_cmd.pos]);
                    end
                end
            end
            ST_ROUND: begin
                w_next     = w_rnd;
                round_next = round_reg + 1'b1;
                if (round_reg == RND_W'(cc20_pkg::NUM_ROUNDS - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                w_next     = w_ff;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = cc20_pkg::make_out(cur_reg, w_reg[cur_reg.pos]);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.pop  = pop;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

endmodule

// ===== rtl/chacha20_stream_cipher.sv =====
// Words inside a keystream block: one word per cycle while m_ready accepts results;
// each word is registered in the queue and in the output register. A word that needs
// a fresh block waits for the load, 20 rounds (one per cycle in the round core), the
// feed-forward and the emit, taking no other word meanwhile. A block is 16 words, 64 bytes.
// Reset (aresetn, synchronous, active low) clears configuration, counters and the queue.
`timescale 1ns / 1ps

module chacha20_stream_cipher #(
    parameter int FIFO_DEPTH = cc20_pkg::CC_FIFO_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cc20_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cc20_pkg::out_t                  m_data
);

    cc20_pkg::cfg_t       cfg_reg, cfg_next;
    logic                 q_push_valid, q_push_ready;
    cc20_pkg::cmd_t       q_push_cmd;
    logic                 q_pop_valid;
    cc20_pkg::cmd_t       q_pop_cmd;
    cc20_pkg::core_stat_t core_stat;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cc20_pkg::CFG_KEY0:     cfg_next.key[0]     = cfg_data;
                cc20_pkg::CFG_KEY1:     cfg_next.key[1]     = cfg_data;
                cc20_pkg::CFG_KEY2:     cfg_next.key[2]     = cfg_data;
                cc20_pkg::CFG_KEY3:     cfg_next.key[3]     = cfg_data;
                cc20_pkg::CFG_NONCE_LO: cfg_next.nonce_low  = cfg_data;
                cc20_pkg::CFG_NONCE_HI: cfg_next.nonce_high = cfg_data[31:0];
                cc20_pkg::CFG_INIT_CTR: cfg_next.init_ctr   = cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cc20_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd)
    );

    cc20_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd),
        .pop_valid  (q_pop_valid),
        .pop_ready  (core_stat.pop),
        .pop_cmd    (q_pop_cmd)
    );

    cc20_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_pop_valid),
        .q_cmd   (q_pop_cmd),
        .stat    (core_stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a first word always opens a fresh block at word zero
    a_first_new_block: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.first |-> q_push_cmd.new_block && q_push_cmd.pos == 4'd0)
        else $error("first word did not start a new block");

    // a word reusing the current block never sits at word zero
    a_reuse_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push_valid && q_push_ready && !q_push_cmd.new_block |-> q_push_cmd.pos != 4'd0)
        else $error("block reused at word zero");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.pop |-> q_pop_valid)
        else $error("core popped an empty queue");

    a_busy_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.busy |-> !core_stat.pop)
        else $error("core popped while computing a block");

endmodule

// ===== tb/chacha20_stream_cipher_tb.sv =====
`timescale 1ns / 1ps

module chacha20_stream_cipher_tb;
    import cc20_pkg::*;

    typedef logic [15:0][31:0] words16_t;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        first;
        bit          typed;
        logic [31:0] word;
    } row_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int LONG_HOLD_CYCLES = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;

    // typed-in expectation riding along with the beat on s_
    bit          drv_typed;
    logic [31:0] drv_typed_word;

    // cipher state as the block should hold it
    logic [63:0] key_reg [0:3];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] ictr_reg;
    words16_t    ks_words;
    logic [31:0] blk_ctr;
    logic [3:0]  ks_pos;
    logic        ks_live;

    out_t pending_out [$];
    int   errors;
    int   cycles;
    bit   quiet;
    bit   long_hold;
    row_t rows [0:15];

    chacha20_stream_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic words16_t qround(input words16_t w, input int a, input int b,
                                        input int c, input int d);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
        return w;
    endfunction

    function automatic words16_t chacha_block(input logic [31:0] ctr);
        words16_t st;
        words16_t w;
        int k;
        st[0]  = 32'h6170_7865;
        st[1]  = 32'h3320_646E;
        st[2]  = 32'h7962_2D32;
        st[3]  = 32'h6B20_6574;
        for (k = 0; k < 4; k++) begin
            st[4 + 2*k] = key_reg[k][31:0];
            st[5 + 2*k] = key_reg[k][63:32];
        end
        st[12] = ctr;
        st[13] = nonce_lo_reg[31:0];
        st[14] = nonce_lo_reg[63:32];
        st[15] = nonce_hi_reg;
        w = st;
        for (k = 0; k < 10; k++) begin
            w = qround(w, 0, 4, 8, 12);
            w = qround(w, 1, 5, 9, 13);
            w = qround(w, 2, 6, 10, 14);
            w = qround(w, 3, 7, 11, 15);
            w = qround(w, 0, 5, 10, 15);
            w = qround(w, 1, 6, 11, 12);
            w = qround(w, 2, 7, 8, 13);
            w = qround(w, 3, 4, 9, 14);
        end
        for (k = 0; k < 16; k++)
            w[k] = w[k] + st[k];
        return w;
    endfunction

    // one keystream word per beat, fresh block on demand
    function automatic out_t cipher_word(input in_t w);
        out_t o;
        logic [31:0] ks;
        logic [31:0] mask;
        if (w.first) begin
            blk_ctr = ictr_reg;
            ks_live = 1'b0;
        end
        if (!ks_live) begin
            ks_words = chacha_block(blk_ctr);
            blk_ctr  = blk_ctr + 32'd1;
            ks_live  = 1'b1;
            ks_pos   = 4'd0;
        end
        ks = ks_words[ks_pos];
        ks_pos = ks_pos + 4'd1;
        if (ks_pos == 4'd0)
            ks_live = 1'b0;
        mask = (w.byte_count >= 3'd4) ? 32'hFFFF_FFFF
                                      : ((32'd1 << (8 * w.byte_count)) - 32'd1);
        o.result_word  = (w.data_word ^ ks) & mask;
        o.result_bytes = w.byte_count;
        return o;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = cipher_word(s_data);
                if (drv_typed)
                    want.result_word = drv_typed_word;
                pending_out.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_out.size() == 0) begin
                    $error("unexpected result beat: result_word %h result_bytes %0d",
                           m_data.result_word, m_data.result_bytes);
                    errors++;
                end else begin
                    want = pending_out.pop_front();
                    if (m_data.result_word !== want.result_word) begin
                        $error("result_word: expected %h, got %h",
                               want.result_word, m_data.result_word);
                        errors++;
                    end
                    if (m_data.result_bytes !== want.result_bytes) begin
                        $error("result_bytes: expected %0d, got %0d",
                               want.result_bytes, m_data.result_bytes);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 5);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_KEY0:     key_reg[0]   = val;
            CFG_KEY1:     key_reg[1]   = val;
            CFG_KEY2:     key_reg[2]   = val;
            CFG_KEY3:     key_reg[3]   = val;
            CFG_NONCE_LO: nonce_lo_reg = val;
            CFG_NONCE_HI: nonce_hi_reg = val[31:0];
            CFG_INIT_CTR: ictr_reg     = val[31:0];
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [31:0] d, input logic [2:0] c, input logic f,
                             input bit typed, input logic [31:0] tw);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_data         <= {d, c, f};
        drv_typed      <= typed;
        drv_typed_word <= tw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_message(input int len, input bit with_first);
        int i;
        for (i = 0; i < len; i++)
            send_word($urandom, (i == len - 1) ? 3'($urandom_range(1, 4)) : 3'd4,
                      with_first && i == 0, 1'b0, 32'h0);
    endtask

    // stop offering, let every result out, then give the core time to go quiet
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_rows(input int lo, input int hi);
        int i;
        for (i = lo; i <= hi; i++)
            send_word(rows[i].data, rows[i].cnt, rows[i].first, rows[i].typed, rows[i].word);
    endtask

    task automatic set_phase_config(input int ph);
        int k;
        logic [31:0] ctr;
        for (k = CFG_KEY0; k <= CFG_INIT_CTR; k++) begin
            case (ph)
                0: cfg_write(k[CFG_IDX_W-1:0], {$urandom, $urandom});
                1: cfg_write(k[CFG_IDX_W-1:0], 64'hFFFF_FFFF_FFFF_FFFF);
                2: cfg_write(k[CFG_IDX_W-1:0], 64'h0);
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        if (k == CFG_INIT_CTR) begin
                            case ($urandom_range(0, 3))
                                0:       ctr = 32'h0;
                                1:       ctr = 32'hFFFF_FFFF;
                                2:       ctr = 32'hFFFF_FFFE;
                                default: ctr = $urandom;
                            endcase
                            cfg_write(k[CFG_IDX_W-1:0], {$urandom, ctr});
                        end else begin
                            cfg_write(k[CFG_IDX_W-1:0], {$urandom, $urandom});
                        end
                    end
                end
            endcase
        end
        if (ph == 0)
            cfg_write(CFG_UNUSED, {$urandom, $urandom});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        int n;
        int r;
        int len;
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        drv_typed = 1'b0;
        drv_typed_word = '0;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        long_hold = 1'b0;
        key_reg[0] = '0; key_reg[1] = '0; key_reg[2] = '0; key_reg[3] = '0;
        nonce_lo_reg = '0;
        nonce_hi_reg = '0;
        ictr_reg = '0;
        ks_words = '0;
        blk_ctr = '0;
        ks_pos = '0;
        ks_live = 1'b0;

        // reset config: no first flag, so the stream opens at counter zero
        rows[0]  = '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0};
        rows[1]  = '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0};
        rows[2]  = '{32'hA5A5_A5A5, 3'd0, 1'b0, 1'b1, 32'h0};
        rows[3]  = '{32'h1234_5678, 3'd1, 1'b0, 1'b0, 32'h0};
        rows[4]  = '{32'h1234_5678, 3'd2, 1'b0, 1'b0, 32'h0};
        rows[5]  = '{32'h1234_5678, 3'd3, 1'b0, 1'b0, 32'h0};
        rows[6]  = '{32'h5A5A_5A5A, 3'd5, 1'b0, 1'b0, 32'h0};
        rows[7]  = '{32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, 32'h0};
        rows[8]  = '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0};
        rows[9]  = '{32'h8000_0001, 3'd4, 1'b0, 1'b0, 32'h0};
        // standard block-function vector: key 00..1f, counter 1
        rows[10] = '{32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'hE4E7_F110};
        rows[11] = '{32'h0000_0000, 3'd4, 1'b0, 1'b1, 32'h1559_3BD1};
        rows[12] = '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b1, 32'h0};
        rows[13] = '{32'hFFFF_FFFF, 3'd6, 1'b0, 1'b0, 32'h0};
        rows[14] = '{32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'hE4E7_F110};
        rows[15] = '{32'h00FF_00FF, 3'd3, 1'b0, 1'b0, 32'h0};

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        run_rows(0, 9);
        drain();
        cfg_write(CFG_KEY0, 64'h0706_0504_0302_0100);
        cfg_write(CFG_KEY1, 64'h0F0E_0D0C_0B0A_0908);
        cfg_write(CFG_KEY2, 64'h1716_1514_1312_1110);
        cfg_write(CFG_KEY3, 64'h1F1E_1D1C_1B1A_1918);
        cfg_write(CFG_NONCE_LO, 64'h4A00_0000_0900_0000);
        cfg_write(CFG_NONCE_HI, 64'h0);
        cfg_write(CFG_INIT_CTR, 64'h1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        run_rows(10, 15);

        for (ph = 0; ph < 12; ph++) begin
            quiet = (ph >= 10);
            drain();
            set_phase_config(ph);
            if (ph == 3)
                long_hold = 1'b1;
            n = 0;
            while (n < 100) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              1'b0, 32'h0);
                    n++;
                end else begin
                    // r == 1: message carried on without a first flag
                    len = (r <= 2) ? $urandom_range(1, 3) : $urandom_range(4, 40);
                    send_message(len, r != 1);
                    n += len;
                end
            end
        end
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cc20_pkg.sv
rtl/cc20_front.sv
rtl/cc20_fifo.sv
rtl/cc20_core.sv
rtl/chacha20_stream_cipher.sv
tb/chacha20_stream_cipher_tb.sv
